// ----- rtl/core/mcp_pkg.sv -----
// Shared types for the max consistent prefix topological order block.
package mcp_pkg;

  localparam int unsigned NODE_W = 7;

  typedef struct packed {
    logic in_ready;
    logic srch_init;
    logic chk_trial;
    logic clr_step;
    logic walk_cnt;
    logic elem_rd;
    logic elem_eval;
    logic deg_upd;
    logic scan_start;
    logic scan_rd;
    logic scan_eval;
    logic find_init;
    logic find_step;
    logic take;
    logic trial_end;
    logic emit_start;
    logic out_none;
    logic best_rd;
    logic out_load;
    logic out_next;
    logic run_clear;
  } mcp_cmd_t;

  typedef struct packed {
    logic in_last;
    logic out_fire;
    logic out_last;
    logic clr_last;
    logic walk_end;
    logic walk_src;
    logic pair_hit;
    logic scan_last;
    logic ready_empty;
    logic bit_set;
    logic search_open;
    logic none_found;
  } mcp_stat_t;

endpackage

// ----- rtl/core/mcp_in_if.sv -----
// Input channel: one observation list element per request.
interface mcp_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] node_id;
  logic       list_end;
  logic       data_end;

  modport source (output valid, node_id, list_end, data_end, input ready);
  modport sink   (input valid, node_id, list_end, data_end, output ready);
endinterface

// ----- rtl/core/mcp_out_if.sv -----
// Result channel: one node of the order per request.
interface mcp_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] order_node;
  logic [6:0] kept_lists;
  logic       found;
  logic       overflow;
  logic       last;

  modport source (output valid, order_node, kept_lists, found, overflow, last, input ready);
  modport sink   (input valid, order_node, kept_lists, found, overflow, last, output ready);
endinterface

// ----- rtl/core/max_consistent_prefix_topo_order_core.sv -----
// Top level: largest consistent prefix of observation lists, smallest-first order.
// Load: one element request per cycle while idle; a data_end request starts the run.
// Run: up to ceil(log2(lists+1)) trials, each a clear sweep of the in-degree store, a count
//   walk over the elements, a scan for zero in-degree, then per placed node a find over the
//   ready bits and a source walk. Emit: each result is read and loaded after the last is taken.
// Reset (rst_n low, synchronous): load counts clear, node_count goes to 64, stores undefined.
module max_consistent_prefix_topo_order_core #(
  parameter int unsigned MAX_NODES    = 64,
  parameter int unsigned MAX_LISTS    = 64,
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  mcp_in_if.sink      in_ch,
  mcp_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mcp_pkg::*;

  mcp_cmd_t  cmd;
  mcp_stat_t stat;
  logic [6:0] node_count_r;

  // config: one register, node_count, at byte address 0
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 7'd64;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      node_count_r <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {25'd0, node_count_r} : 32'd0;

  // input request taken only while the sequencer is idle
  assign in_ch.ready = cmd.in_ready;

  mcp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  mcp_dpath #(
    .MAX_NODES    (MAX_NODES),
    .MAX_LISTS    (MAX_LISTS),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .node_count_i     (node_count_r),
    .in_valid_i       (in_ch.valid),
    .in_node_id_i     (in_ch.node_id),
    .in_list_end_i    (in_ch.list_end),
    .in_data_end_i    (in_ch.data_end),
    .out_ready_i      (out_ch.ready),
    .out_valid_o      (out_ch.valid),
    .out_order_node_o (out_ch.order_node),
    .out_kept_lists_o (out_ch.kept_lists),
    .out_found_o      (out_ch.found),
    .out_overflow_o   (out_ch.overflow),
    .out_last_o       (out_ch.last)
  );

  // no load while a result is pending
  a_no_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result is pending");

  // a failed run gives a single closing result
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.last && out_ch.order_node == 7'd0))
    else $error("not-found result malformed");

  // a found order keeps at least one list and names a real node
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.found) |-> (out_ch.kept_lists != 7'd0 && out_ch.order_node != 7'd0))
    else $error("found result without lists or node");

  // after the final result is taken the block returns to load
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("no return to load after final result");

endmodule

// ----- rtl/core/mcp_ctrl.sv -----
// Sequencer for load, binary search, Kahn trials and result emission.
module mcp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  mcp_pkg::mcp_stat_t stat_i,
  output mcp_pkg::mcp_cmd_t  cmd_o
);
  import mcp_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INIT  = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_CLR   = 5'd3;
  localparam logic [4:0] S_WRD   = 5'd4;
  localparam logic [4:0] S_WEL   = 5'd5;
  localparam logic [4:0] S_WUPD  = 5'd6;
  localparam logic [4:0] S_SRD   = 5'd7;
  localparam logic [4:0] S_SEV   = 5'd8;
  localparam logic [4:0] S_PICK  = 5'd9;
  localparam logic [4:0] S_FIND  = 5'd10;
  localparam logic [4:0] S_TEND  = 5'd11;
  localparam logic [4:0] S_ORD   = 5'd12;
  localparam logic [4:0] S_OLD   = 5'd13;
  localparam logic [4:0] S_OWAIT = 5'd14;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_last) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.srch_init = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat_i.search_open) begin
          cmd_o.chk_trial = 1'b1;
          state_nxt = S_CLR;
        end else begin
          cmd_o.emit_start = 1'b1;
          if (stat_i.none_found) begin
            cmd_o.out_none = 1'b1;
            state_nxt = S_OWAIT;
          end else begin
            state_nxt = S_ORD;
          end
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          cmd_o.walk_cnt = 1'b1;
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        if (stat_i.walk_end) begin
          if (stat_i.walk_src) begin
            state_nxt = S_PICK;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_nxt = S_SRD;
          end
        end else begin
          cmd_o.elem_rd = 1'b1;
          state_nxt = S_WEL;
        end
      end
      S_WEL: begin
        cmd_o.elem_eval = 1'b1;
        state_nxt = stat_i.pair_hit ? S_WUPD : S_WRD;
      end
      S_WUPD: begin
        cmd_o.deg_upd = 1'b1;
        state_nxt = S_WRD;
      end
      S_SRD: begin
        cmd_o.scan_rd = 1'b1;
        state_nxt = S_SEV;
      end
      S_SEV: begin
        cmd_o.scan_eval = 1'b1;
        state_nxt = stat_i.scan_last ? S_PICK : S_SRD;
      end
      S_PICK: begin
        if (stat_i.ready_empty) begin
          state_nxt = S_TEND;
        end else begin
          cmd_o.find_init = 1'b1;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        if (stat_i.bit_set) begin
          cmd_o.take = 1'b1;
          state_nxt = S_WRD;
        end else begin
          cmd_o.find_step = 1'b1;
        end
      end
      S_TEND: begin
        cmd_o.trial_end = 1'b1;
        state_nxt = S_CHK;
      end
      S_ORD: begin
        cmd_o.best_rd = 1'b1;
        state_nxt = S_OLD;
      end
      S_OLD: begin
        cmd_o.out_load = 1'b1;
        state_nxt = S_OWAIT;
      end
      S_OWAIT: begin
        if (stat_i.out_fire) begin
          cmd_o.out_next = 1'b1;
          if (stat_i.out_last) begin
            cmd_o.run_clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/mcp_dpath.sv -----
// Datapath: element, list end, in-degree and order stores with their counters.
module mcp_dpath #(
  parameter int unsigned MAX_NODES    = 64,
  parameter int unsigned MAX_LISTS    = 64,
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mcp_pkg::mcp_cmd_t  cmd_i,
  output mcp_pkg::mcp_stat_t stat_o,
  input  logic [6:0]        node_count_i,
  input  logic              in_valid_i,
  input  logic [6:0]        in_node_id_i,
  input  logic              in_list_end_i,
  input  logic              in_data_end_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [6:0]        out_order_node_o,
  output logic [6:0]        out_kept_lists_o,
  output logic              out_found_o,
  output logic              out_overflow_o,
  output logic              out_last_o
);
  import mcp_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_NODES);
  localparam int unsigned AW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned LW  = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int unsigned LCW = $clog2(MAX_LISTS + 1);
  localparam logic [NODE_W-1:0] MN   = NODE_W'(MAX_NODES);
  localparam logic [IW-1:0]     IMAX = IW'(MAX_NODES - 1);

  // stores
  logic [NODE_W:0]   elem_mem  [MAX_ELEMENTS];
  logic [CW-1:0]     lep_mem   [MAX_LISTS];
  logic [CW-1:0]     deg_mem   [MAX_NODES];
  logic [NODE_W-1:0] order_mem [2*MAX_NODES];

  logic [CW-1:0]     ec_r;
  logic [LCW-1:0]    lc_r;
  logic              ovf_r;
  logic              start_pend_r;
  logic [LCW-1:0]    lo_r, hi_r, nl_r;
  logic [CW-1:0]     lep_rd_r;
  logic [IW-1:0]     idx_r;
  logic [CW-1:0]     p_r;
  logic              mode_src_r;
  logic [NODE_W-1:0] src_r, cur_r;
  logic [NODE_W:0]   elem_rd_r;
  logic [CW-1:0]     deg_rd_r;
  logic [MAX_NODES-1:0] ready_r;
  logic [IW-1:0]     bit_r;
  logic [NODE_W-1:0] cnt_r;
  logic              bank_r;
  logic [NODE_W-1:0] emit_r;
  logic [NODE_W-1:0] ord_rd_r;
  logic              out_valid_r;

  logic [NODE_W-1:0] nc;
  logic              load, drop, close;
  logic [CW-1:0]     ec_after;
  logic [LCW:0]      nl_sum;
  logic [NODE_W-1:0] b_new;
  logic              a_ok, b_ok;
  logic [CW-1:0]     deg_nv;
  logic [IW-1:0]     deg_raddr;
  logic [NODE_W-1:0] bit_node;

  always_comb begin
    if (node_count_i == '0) begin
      nc = NODE_W'(1);
    end else if (node_count_i > MN) begin
      nc = MN;
    end else begin
      nc = node_count_i;
    end
  end

  assign load     = in_valid_i & cmd_i.in_ready;
  assign drop     = (lc_r >= LCW'(MAX_LISTS)) || (ec_r >= CW'(MAX_ELEMENTS));
  assign close    = in_list_end_i | in_data_end_i;
  assign ec_after = drop ? ec_r : ec_r + CW'(1);
  assign nl_sum   = {1'b0, lo_r} + {1'b0, hi_r} + (LCW + 1)'(1);

  assign b_new  = elem_rd_r[NODE_W-1:0];
  assign a_ok   = (cur_r != '0) && (cur_r <= nc);
  assign b_ok   = (b_new != '0) && (b_new <= nc);
  assign deg_nv = mode_src_r ? deg_rd_r - CW'(1) : deg_rd_r + CW'(1);
  assign deg_raddr = cmd_i.scan_rd ? idx_r : IW'(b_new - NODE_W'(1));
  assign bit_node  = NODE_W'(bit_r) + NODE_W'(1);

  // load state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r         <= '0;
      lc_r         <= '0;
      ovf_r        <= 1'b0;
      start_pend_r <= 1'b1;
    end else if (cmd_i.run_clear) begin
      ec_r         <= '0;
      lc_r         <= '0;
      ovf_r        <= 1'b0;
      start_pend_r <= 1'b1;
    end else if (load) begin
      ec_r <= ec_after;
      if (drop) begin
        ovf_r <= 1'b1;
      end else begin
        start_pend_r <= 1'b0;
      end
      if (close) begin
        if (lc_r < LCW'(MAX_LISTS)) begin
          lc_r         <= lc_r + LCW'(1);
          start_pend_r <= 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !drop) begin
      elem_mem[ec_r[AW-1:0]] <= {start_pend_r, in_node_id_i};
    end
    if (cmd_i.elem_rd) begin
      elem_rd_r <= elem_mem[p_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load && close && (lc_r < LCW'(MAX_LISTS))) begin
      lep_mem[lc_r[LW-1:0]] <= ec_after;
    end
    if (cmd_i.chk_trial) begin
      lep_rd_r <= lep_mem[LW'(nl_sum[LCW:1] - (LCW)'(1))];
    end
  end

  // in-degree store: clear sweep and read-modify-write
  always_ff @(posedge clk) begin
    if (cmd_i.clr_step) begin
      deg_mem[idx_r] <= '0;
    end else if (cmd_i.deg_upd) begin
      deg_mem[IW'(cur_r - NODE_W'(1))] <= deg_nv;
    end
    if (cmd_i.scan_rd || (cmd_i.elem_eval && stat_o.pair_hit)) begin
      deg_rd_r <= deg_mem[deg_raddr];
    end
  end

  // order store, two banks: the best order and the trial in progress
  always_ff @(posedge clk) begin
    if (cmd_i.take) begin
      order_mem[{~bank_r, cnt_r[IW-1:0]}] <= bit_node;
    end
    if (cmd_i.best_rd) begin
      ord_rd_r <= order_mem[{bank_r, emit_r[IW-1:0]}];
    end
  end

  // search bounds and trial bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else if (cmd_i.trial_end && (cnt_r == nc)) begin
      bank_r <= ~bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.srch_init) begin
      lo_r <= '0;
      hi_r <= lc_r;
    end else if (cmd_i.trial_end) begin
      if (cnt_r == nc) begin
        lo_r <= nl_r;
      end else begin
        hi_r <= nl_r - LCW'(1);
      end
    end
    if (cmd_i.chk_trial) begin
      nl_r <= nl_sum[LCW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.chk_trial || cmd_i.scan_start) begin
      idx_r <= '0;
    end else if (cmd_i.clr_step || cmd_i.scan_eval) begin
      idx_r <= idx_r + IW'(1);
    end

    if (cmd_i.chk_trial) begin
      ready_r <= '0;
      cnt_r   <= '0;
    end else if (cmd_i.scan_eval) begin
      if (deg_rd_r == '0) begin
        ready_r[idx_r] <= 1'b1;
      end
    end else if (cmd_i.deg_upd) begin
      if (mode_src_r && (deg_nv == '0)) begin
        ready_r[IW'(cur_r - NODE_W'(1))] <= 1'b1;
      end
    end else if (cmd_i.take) begin
      ready_r[bit_r] <= 1'b0;
      cnt_r          <= cnt_r + NODE_W'(1);
    end

    if (cmd_i.find_init) begin
      bit_r <= '0;
    end else if (cmd_i.find_step) begin
      bit_r <= bit_r + IW'(1);
    end

    if (cmd_i.walk_cnt || cmd_i.take) begin
      p_r        <= '0;
      cur_r      <= '0;
      mode_src_r <= cmd_i.take;
      src_r      <= bit_node;
    end else if (cmd_i.elem_eval) begin
      p_r   <= p_r + CW'(1);
      cur_r <= b_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load || cmd_i.out_none) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit_start) begin
      emit_r <= '0;
    end else if (cmd_i.out_next) begin
      emit_r <= emit_r + NODE_W'(1);
    end
    if (cmd_i.out_none) begin
      out_order_node_o <= '0;
      out_kept_lists_o <= '0;
      out_found_o      <= 1'b0;
      out_overflow_o   <= ovf_r;
      out_last_o       <= 1'b1;
    end else if (cmd_i.out_load) begin
      out_order_node_o <= ord_rd_r;
      out_kept_lists_o <= NODE_W'(lo_r);
      out_found_o      <= 1'b1;
      out_overflow_o   <= ovf_r;
      out_last_o       <= (emit_r == nc - NODE_W'(1));
    end
  end

  assign out_valid_o = out_valid_r;

  always_comb begin
    stat_o             = '0;
    stat_o.in_last     = load & in_data_end_i;
    stat_o.out_fire    = out_valid_r & out_ready_i;
    stat_o.out_last    = out_last_o;
    stat_o.clr_last    = (idx_r == IMAX);
    stat_o.walk_end    = (p_r >= lep_rd_r);
    stat_o.walk_src    = mode_src_r;
    stat_o.pair_hit    = !elem_rd_r[NODE_W] && a_ok && b_ok && (!mode_src_r || cur_r == src_r);
    stat_o.scan_last   = (NODE_W'(idx_r) == nc - NODE_W'(1));
    stat_o.ready_empty = (ready_r == '0);
    stat_o.bit_set     = ready_r[bit_r];
    stat_o.search_open = (lo_r < hi_r);
    stat_o.none_found  = (lo_r == '0);
  end

endmodule

// ----- sim/mcp_tb_if.sv -----
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from the RTL tree; this file holds shared tb types.
package mcp_tb_pkg;

  localparam int unsigned REG_NODE_COUNT = 0;

  typedef struct packed {
    logic [6:0] node;
    logic [6:0] kept;
    logic       found;
    logic       ovf;
    logic       last;
  } order_res_t;

  typedef struct packed {
    logic [6:0] nid;
    logic       le;
    logic       de;
    logic       typed;
    order_res_t want;
  } stim_row_t;

endpackage

// ----- sim/tb_max_consistent_prefix_topo_order_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the max consistent prefix topological order core.
module tb_max_consistent_prefix_topo_order_core;
  import mcp_pkg::*;
  import mcp_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int CAP_NODES      = 64;
  localparam int CAP_LISTS      = 64;
  localparam int CAP_ELEMS      = 1024;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  mcp_in_if  in_ch ();
  mcp_out_if out_ch ();

  max_consistent_prefix_topo_order_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the block: load store, list ends, node_count and the order search
  // ---------------------------------------------------------------------------
  logic [6:0]  elem_mem [CAP_ELEMS];
  int          list_ptr [CAP_LISTS];
  int          elem_cnt, list_cnt;
  bit          ovf_seen;
  logic [6:0]  node_cfg;
  int          trial_ord [CAP_NODES];
  int          best_ord  [CAP_NODES];
  order_res_t  order_q [$];

  int errs, mism, reqs_in, reqs_out, runs_done;
  bit in_fire, out_fire, long_hold_done, quiet;

  // append one expected result
  function automatic void queue_result(order_res_t r);
    order_q = {order_q, r};
  endfunction

  // Kahn's sort on the leading nl lists, smallest ready node first
  function automatic bit kahn_ok(int nl, int nc);
    int indeg [CAP_NODES + 1];
    logic [63:0] rdy;
    int cnt, s, e, a, b, v;
    for (int i = 0; i <= CAP_NODES; i++) indeg[i] = 0;
    for (int k = 0; k < nl; k++) begin
      s = (k == 0) ? 0 : list_ptr[k - 1];
      e = list_ptr[k];
      for (int p = s + 1; p < e && p < CAP_ELEMS; p++) begin
        a = elem_mem[p - 1]; b = elem_mem[p];
        if (a >= 1 && a <= nc && b >= 1 && b <= nc) indeg[b]++;
      end
    end
    rdy = '0;
    for (int i = 1; i <= nc; i++) if (indeg[i] == 0) rdy[i - 1] = 1'b1;
    cnt = 0;
    while (rdy != 0 && cnt < CAP_NODES) begin
      v = 0;
      while (!rdy[v]) v++;
      rdy[v] = 1'b0;
      v = v + 1;
      trial_ord[cnt++] = v;
      for (int k = 0; k < nl; k++) begin
        s = (k == 0) ? 0 : list_ptr[k - 1];
        e = list_ptr[k];
        for (int p = s + 1; p < e && p < CAP_ELEMS; p++) begin
          a = elem_mem[p - 1]; b = elem_mem[p];
          if (a == v && b >= 1 && b <= nc) begin
            indeg[b]--;
            if (indeg[b] == 0) rdy[b - 1] = 1'b1;
          end
        end
      end
    end
    return cnt == nc;
  endfunction

  // Load one element into the shadow; a data_end request runs the search
  task automatic forecast_order(logic [6:0] nid, logic le, logic de);
    int nc, lo, hi, mid;
    order_res_t r;
    if (list_cnt >= CAP_LISTS || elem_cnt >= CAP_ELEMS) ovf_seen = 1;
    else elem_mem[elem_cnt++] = nid;
    if (le || de) begin
      if (list_cnt < CAP_LISTS) list_ptr[list_cnt++] = elem_cnt;
      else ovf_seen = 1;
    end
    if (!de) return;
    nc = node_cfg;
    if (nc < 1) nc = 1;
    if (nc > CAP_NODES) nc = CAP_NODES;
    lo = -1;
    hi = list_cnt - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (kahn_ok(mid + 1, nc)) begin
        lo = mid;
        best_ord = trial_ord;
      end else begin
        hi = mid - 1;
      end
    end
    if (lo < 0) begin
      r = '{node: 7'd0, kept: 7'd0, found: 1'b0, ovf: ovf_seen, last: 1'b1};
      queue_result(r);
    end else begin
      for (int i = 0; i < nc; i++) begin
        r = '{node: best_ord[i][6:0], kept: 7'(lo + 1), found: 1'b1, ovf: ovf_seen,
              last: (i + 1 == nc)};
        queue_result(r);
      end
    end
    elem_cnt = 0;
    list_cnt = 0;
    ovf_seen = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: called at a rising edge, returns at the edge of acceptance
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    if (quiet) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7:       return $urandom_range(1, 3);
      8:             return $urandom_range(4, 8);
      default:       return $urandom_range(15, 60);
    endcase
  endfunction

  task automatic push_elem(logic [6:0] nid, logic le, logic de);
    int g;
    bit ok;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.node_id  <= nid;
    in_ch.list_end <= le;
    in_ch.data_end <= de;
    do begin
      @(negedge clk);
      ok = in_ch.valid && in_ch.ready;
      @(posedge clk);
    end while (!ok);
    reqs_in++;
    if (de) runs_done++;
    forecast_order(nid, le, de);
  endtask

  // Config writes only once the block has drained; extra cycles cover the run_clear tail
  task automatic write_node_count(logic [6:0] v);
    logic [31:0] rb;
    in_ch.valid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(REG_NODE_COUNT * 4); pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rb = prdata;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    node_cfg = v;
    if (rb[6:0] !== v) begin
      errs++;
      $display("node_count readback: wrote %0d read %0d", v, rb[6:0]);
    end
    @(posedge clk);
  endtask

  // One random run: mostly lists drawn in order from a hidden permutation,
  // so long prefixes stay consistent; some lists are reversed or noisy.
  task automatic random_run(int nc_eff, output int n_items);
    int perm [CAP_NODES];
    int nl, len, pos, t, j;
    logic [6:0] id;
    bit rev;
    n_items = 0;
    for (int i = 0; i < nc_eff; i++) perm[i] = i + 1;
    for (int i = nc_eff - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    nl = $urandom_range(1, 6);
    for (int k = 0; k < nl; k++) begin
      len = $urandom_range(1, 5);
      rev = ($urandom_range(0, 5) == 0);
      pos = $urandom_range(0, nc_eff - 1);
      for (int m = 0; m < len; m++) begin
        if ($urandom_range(0, 9) == 0) id = 7'($urandom_range(0, 127));
        else if ($urandom_range(0, 9) == 0) id = 7'($urandom_range(1, nc_eff));
        else id = 7'(perm[rev ? (nc_eff - 1 - pos) : pos]);
        pos = (pos + $urandom_range(1, 3)) % nc_eff;
        if (k == nl - 1 && m == len - 1) push_elem(id, 1'($urandom_range(0, 1)), 1'b1);
        else push_elem(id, (m == len - 1), 1'b0);
        n_items++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, quiet stretches, one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int g;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && reqs_out >= 100) begin
        // long hold: the sender keeps offering while results back up
        out_ch.ready <= 1'b0;
        repeat (800) @(posedge clk);
        long_hold_done = 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Quiet stretches with no idling on either side
  initial begin
    quiet = 0;
    forever begin
      repeat ($urandom_range(300, 900)) @(posedge clk);
      quiet = ~quiet;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(negedge clk) begin
    order_res_t got, exp_r;
    in_fire  <= in_ch.valid && in_ch.ready;
    out_fire <= out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{node: out_ch.order_node, kept: out_ch.kept_lists, found: out_ch.found,
              ovf: out_ch.overflow, last: out_ch.last};
      reqs_out++;
      if (order_q.size() == 0) begin
        errs++;
        if (++mism <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = order_q.pop_front();
        if (got !== exp_r) begin
          errs++;
          if (++mism <= 10) $display("result %0d: expected %p got %p", reqs_out, exp_r, got);
        end
      end
    end
  end

  // Watchdog: cycles without any handshake
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (in_fire || out_fire) idle = 0;
      else idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", order_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: nodes 1..3; typed rows carry the no-prefix result
  // ---------------------------------------------------------------------------
  localparam order_res_t NONE_RES = '{node: 7'd0, kept: 7'd0, found: 1'b0, ovf: 1'b0,
                                      last: 1'b1};
  localparam order_res_t NO_RES = '0;
  localparam int N_DIR = 21;
  stim_row_t dir_tab [N_DIR] = '{
    '{7'd1,   1'b1, 1'b0, 1'b0, NO_RES},   // two single-node lists, no edges
    '{7'd1,   1'b0, 1'b1, 1'b0, NO_RES},
    '{7'd2,   1'b0, 1'b0, 1'b0, NO_RES},   // repeated node: self loop, nothing fits
    '{7'd2,   1'b0, 1'b1, 1'b1, NONE_RES},
    '{7'd3,   1'b0, 1'b0, 1'b0, NO_RES},   // descending chain
    '{7'd2,   1'b0, 1'b0, 1'b0, NO_RES},
    '{7'd1,   1'b0, 1'b1, 1'b0, NO_RES},
    '{7'd0,   1'b0, 1'b0, 1'b0, NO_RES},   // ids out of range are stored but ignored
    '{7'd127, 1'b1, 1'b0, 1'b0, NO_RES},
    '{7'd1,   1'b0, 1'b0, 1'b0, NO_RES},
    '{7'd2,   1'b0, 1'b1, 1'b0, NO_RES},
    '{7'd1,   1'b0, 1'b0, 1'b0, NO_RES},   // second list contradicts the first
    '{7'd2,   1'b1, 1'b0, 1'b0, NO_RES},
    '{7'd2,   1'b0, 1'b0, 1'b0, NO_RES},
    '{7'd1,   1'b1, 1'b1, 1'b0, NO_RES},
    '{7'd64,  1'b0, 1'b1, 1'b0, NO_RES},   // lone out-of-range element
    '{7'd3,   1'b1, 1'b0, 1'b0, NO_RES},   // cycle in the second list only
    '{7'd1,   1'b0, 1'b0, 1'b0, NO_RES},
    '{7'd1,   1'b0, 1'b1, 1'b0, NO_RES},
    '{7'd3,   1'b0, 1'b0, 1'b0, NO_RES},   // 3 before 1: order 2, 3, 1
    '{7'd1,   1'b1, 1'b1, 1'b0, NO_RES}
  };

  initial begin
    logic [6:0] cfg_walk [8] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd12, 7'd2, 7'd8};
    int n, budget, nc_eff;
    errs = 0; mism = 0; reqs_in = 0; reqs_out = 0; runs_done = 0;
    long_hold_done = 0;
    elem_cnt = 0; list_cnt = 0; ovf_seen = 0; node_cfg = 7'd64;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0; in_ch.node_id <= '0; in_ch.list_end <= 1'b0; in_ch.data_end <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of node_count: one item gives the identity order 1..64
    push_elem(7'd1, 1'b0, 1'b1);

    write_node_count(7'd3);
    foreach (dir_tab[i]) begin
      push_elem(dir_tab[i].nid, dir_tab[i].le, dir_tab[i].de);
      if (dir_tab[i].typed) begin
        void'(order_q.pop_back());
        queue_result(dir_tab[i].want);
      end
    end

    // random runs across node_count settings, extremes included
    foreach (cfg_walk[c]) begin
      write_node_count(cfg_walk[c]);
      nc_eff = (cfg_walk[c] < 1) ? 1 : (cfg_walk[c] > CAP_NODES) ? CAP_NODES : cfg_walk[c];
      budget = 30;
      while (budget > 0) begin
        random_run(nc_eff, n);
        budget -= n;
      end
    end

    // list capacity: 66 single-node lists, the extra closes are dropped
    write_node_count(7'd4);
    for (int k = 0; k < 66; k++)
      push_elem(7'($urandom_range(0, 5)), 1'b1, (k == 65));

    in_ch.valid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d element requests in %0d runs, %0d order results checked, %0d errors",
             reqs_in, runs_done, reqs_out, errs);
    $display("node_count settings 0..127, list capacity overflow, long sink hold");
    if (errs == 0 && order_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
